// File: rtl/gnbm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the Gaussian noise source.
// Used by gnbm_mt, gnbm_math and the top level; depends on nothing else.
package gnbm_pkg;

    localparam int SAMPLE_FRAC_BITS = 12;
    localparam int OUT_SHIFT        = 54 - SAMPLE_FRAC_BITS;

    localparam int MT_N     = 624;
    localparam int MT_M     = 397;
    localparam int MT_IDX_W = $clog2(MT_N);

    localparam logic [31:0] SEED_RESET  = 32'd5489;
    localparam logic [31:0] MT_MULT     = 32'd1812433253;
    localparam logic [31:0] MT_MATRIX   = 32'h9908b0df;
    localparam logic [31:0] TWO_LN2_Q30 = 32'd1488522236;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] Q30_ONE     = 31'h40000000;

    typedef struct packed {
        logic ready;
        logic word_valid;
    } t_mt_status;

    function automatic logic [31:0] mt_temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Divisor of the k-th Taylor term: (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
    function automatic logic [7:0] taylor_div(input logic is_cos, input logic [2:0] k);
        logic [7:0] d;
        case ({is_cos, k})
            4'b0001: d = 8'd6;
            4'b0010: d = 8'd20;
            4'b0011: d = 8'd42;
            4'b0100: d = 8'd72;
            4'b0101: d = 8'd110;
            4'b0110: d = 8'd156;
            4'b1001: d = 8'd2;
            4'b1010: d = 8'd12;
            4'b1011: d = 8'd30;
            4'b1100: d = 8'd56;
            4'b1101: d = 8'd90;
            4'b1110: d = 8'd132;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor) for the same divisors. For dividends below 2^31 the
    // quotient taken from the top half of the product is exact or one short.
    function automatic logic [31:0] taylor_recip(input logic is_cos, input logic [2:0] k);
        logic [31:0] r;
        case ({is_cos, k})
            4'b0001: r = 32'd715827882;
            4'b0010: r = 32'd214748364;
            4'b0011: r = 32'd102261126;
            4'b0100: r = 32'd59652323;
            4'b0101: r = 32'd39045157;
            4'b0110: r = 32'd27531841;
            4'b1001: r = 32'd2147483648;
            4'b1010: r = 32'd357913941;
            4'b1011: r = 32'd143165576;
            4'b1100: r = 32'd76695844;
            4'b1101: r = 32'd47721858;
            4'b1110: r = 32'd32537631;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [30:0] clamp_unit(input logic signed [32:0] v);
        logic [30:0] c;
        if (v[32]) begin
            c = '0;
        end else if (v > $signed({2'b00, Q30_ONE})) begin
            c = Q30_ONE;
        end else begin
            c = v[30:0];
        end
        return c;
    endfunction

    // Rounded product, shifted down to the sample grid, signed and saturated.
    function automatic logic [15:0] sat_out(input logic [63:0] rnd, input logic neg);
        logic [63:0] p;
        logic [15:0] v;
        p = rnd >> OUT_SHIFT;
        if (neg) begin
            v = (p > 64'd32768) ? 16'h8000 : 16'(-p);
        end else begin
            v = (p > 64'd32767) ? 16'h7fff : p[15:0];
        end
        return v;
    endfunction

endpackage

// File: rtl/gnbm_mt.sv
`timescale 1ns / 1ps
// MT19937 word generator: 624-word state memory, seeding sweep, twist and tempering.
// Depends on gnbm_pkg.
module gnbm_mt import gnbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_req,
    output logic [31:0] o_word,
    output t_mt_status  o_status
);

    typedef enum logic [6:0] {
        M_SEED = 7'b0000001,
        M_IDLE = 7'b0000010,
        M_TW0  = 7'b0000100,
        M_TW0W = 7'b0001000,
        M_TWRD = 7'b0010000,
        M_TWWR = 7'b0100000,
        M_RD   = 7'b1000000
    } t_mt_state;

    localparam logic [MT_IDX_W-1:0] LAST_IDX = MT_IDX_W'(MT_N - 1);

    t_mt_state           r_state, n_state;
    logic [MT_IDX_W-1:0] r_i, n_i;
    logic [MT_IDX_W-1:0] r_pos, n_pos;
    logic [31:0]         r_prev, n_prev;
    logic [31:0]         r_cur, n_cur;
    logic [31:0]         r_word, n_word;
    logic                r_wvld, n_wvld;
    logic                r_rdw, n_rdw;

    logic [31:0]         mem [MT_N];
    logic [31:0]         r_rd_a, r_rd_b;
    logic [MT_IDX_W-1:0] addr_a, addr_b, waddr;
    logic                we;
    logic [31:0]         wdata;

    logic [MT_IDX_W-1:0] i_next, i_far;
    logic [MT_IDX_W:0]   far_sum;
    logic [31:0]         seed_next, y, tw;

    always_comb begin
        i_next  = (r_i == LAST_IDX) ? '0 : r_i + 1'b1;
        far_sum = {1'b0, r_i} + (MT_IDX_W + 1)'(MT_M);
        i_far   = (far_sum >= (MT_IDX_W + 1)'(MT_N)) ?
                  MT_IDX_W'(far_sum - (MT_IDX_W + 1)'(MT_N)) : far_sum[MT_IDX_W-1:0];
        seed_next = 32'(MT_MULT * (r_prev ^ (r_prev >> 30))) + {{(32 - MT_IDX_W){1'b0}}, r_i};
        y  = {r_cur[31], r_rd_a[30:0]};
        tw = r_rd_b ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_pos   = r_pos;
        n_prev  = r_prev;
        n_cur   = r_cur;
        n_word  = r_word;
        n_wvld  = 1'b0;
        n_rdw   = 1'b0;
        addr_a  = r_pos;
        addr_b  = i_far;
        waddr   = r_i;
        we      = 1'b0;
        wdata   = seed_next;
        case (r_state)
            M_SEED: begin
                we     = 1'b1;
                wdata  = (r_i == '0) ? r_prev : seed_next;
                n_prev = wdata;
                if (r_i == LAST_IDX) begin
                    n_pos   = MT_IDX_W'(MT_N);
                    n_state = M_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            M_IDLE: begin
                if (i_req) begin
                    if (r_pos == MT_IDX_W'(MT_N)) begin
                        n_i     = '0;
                        n_state = M_TW0;
                    end else begin
                        n_state = M_RD;
                    end
                end
            end
            M_TW0: begin
                addr_a  = '0;
                n_state = M_TW0W;
            end
            M_TW0W: begin
                n_cur   = r_rd_a;
                n_state = M_TWRD;
            end
            M_TWRD: begin
                addr_a  = i_next;
                addr_b  = i_far;
                n_state = M_TWWR;
            end
            M_TWWR: begin
                we    = 1'b1;
                wdata = tw;
                n_cur = r_rd_a;
                if (r_i == LAST_IDX) begin
                    n_pos   = '0;
                    n_state = M_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = M_TWRD;
                end
            end
            M_RD: begin
                // The word read here is tempered in the next cycle.
                addr_a  = r_pos;
                n_rdw   = 1'b1;
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
        if (r_rdw) begin
            n_word = mt_temper(r_rd_a);
            n_wvld = 1'b1;
            n_pos  = r_pos + 1'b1;
        end
        if (i_cfg_we) begin
            n_prev  = i_cfg_wdata;
            n_i     = '0;
            n_state = M_SEED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_SEED;
            r_i     <= '0;
            r_pos   <= MT_IDX_W'(MT_N);
            r_prev  <= SEED_RESET;
            r_wvld  <= 1'b0;
            r_rdw   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_pos   <= n_pos;
            r_prev  <= n_prev;
            r_wvld  <= n_wvld;
            r_rdw   <= n_rdw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_word <= n_word;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    assign o_word              = r_word;
    assign o_status.ready      = (r_state == M_IDLE) && !r_rdw && !r_wvld;
    assign o_status.word_valid = r_wvld;

endmodule

// File: rtl/gnbm_math.sv
`timescale 1ns / 1ps
// Box-Muller arithmetic: log, radius, phase, Taylor sine/cosine and output scaling,
// all on one shared 32x32 multiplier, divisions by reciprocal. Depends on gnbm_pkg.
module gnbm_math import gnbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_word_a,
    input  logic [31:0] i_word_b,
    output logic        o_done,
    output logic [15:0] o_sample_cos,
    output logic [15:0] o_sample_sin
);

    typedef enum logic [20:0] {
        C_IDLE = 21'b000000000000000000001,
        C_NORM = 21'b000000000000000000010,
        C_LOGM = 21'b000000000000000000100,
        C_LOGU = 21'b000000000000000001000,
        C_SM   = 21'b000000000000000010000,
        C_SU   = 21'b000000000000000100000,
        C_SQM  = 21'b000000000000001000000,
        C_SQU  = 21'b000000000000010000000,
        C_TM   = 21'b000000000000100000000,
        C_TU   = 21'b000000000001000000000,
        C_T2M  = 21'b000000000010000000000,
        C_T2U  = 21'b000000000100000000000,
        C_TRM  = 21'b000000001000000000000,
        C_TRU  = 21'b000000010000000000000,
        C_DVM  = 21'b000000100000000000000,
        C_DVU  = 21'b000001000000000000000,
        C_CHM  = 21'b000010000000000000000,
        C_CHU  = 21'b000100000000000000000,
        C_ACC  = 21'b001000000000000000000,
        C_OM   = 21'b010000000000000000000,
        C_OU   = 21'b100000000000000000000
    } t_math_state;

    localparam logic [35:0] LOG_TOP = 36'd33 << 30;

    t_math_state r_state, n_state;
    logic [32:0] r_m33, n_m33;
    logic [30:0] r_m, n_m;
    logic [5:0]  r_e, n_e;
    logic [4:0]  r_it, n_it;
    logic [29:0] r_frac, n_frac;
    logic [32:0] r_ph, n_ph;
    logic [29:0] r_s, n_s;
    logic [26:0] r_r, n_r;
    logic [4:0]  r_bk, n_bk;
    logic [30:0] r_t, n_t;
    logic [30:0] r_t2, n_t2;
    logic [30:0] r_term, n_term;
    logic signed [32:0] r_sum, n_sum;
    logic [2:0]  r_k, n_k;
    logic        r_pass, n_pass;
    logic [30:0] r_st, n_st;
    logic [30:0] r_ct, n_ct;
    logic [30:0] r_dvd, n_dvd;
    logic [30:0] r_quo, n_quo;
    logic        r_oc, n_oc;
    logic [15:0] r_cos, n_cos;
    logic [15:0] r_sin, n_sin;
    logic        r_done, n_done;
    logic [63:0] r_prod;

    logic [31:0] op_a, op_b;
    logic [2:0]  oct;
    logic [30:0] g;
    logic [35:0] big;
    logic [26:0] trial;
    logic [63:0] nsq;
    logic [32:0] sq;
    logic [7:0]  divisor;
    logic [31:0] recip;
    logic [30:0] rem_est;
    logic signed [32:0] sum_n;
    logic [30:0] mag_c, mag_s;
    logic        cneg, sneg;
    logic [63:0] rnd;

    always_comb begin
        oct   = r_ph[32:30];
        g     = oct[0] ? (Q30_ONE - {1'b0, r_ph[29:0]}) : {1'b0, r_ph[29:0]};
        big   = LOG_TOP - {r_e, r_frac};
        trial = r_r | (27'd1 << r_bk);
        nsq   = {10'd0, r_s, 24'd0};
        sq    = r_prod[62:30];
        divisor = taylor_div(r_pass, r_k);
        recip   = taylor_recip(r_pass, r_k);
        rem_est = r_dvd - r_prod[30:0];
        sum_n   = r_k[0] ? r_sum - $signed({2'b00, r_quo}) : r_sum + $signed({2'b00, r_quo});
        // Odd quarter-turn halves swap sine and cosine; the octant sets the signs.
        mag_c = (oct[0] ^ oct[1]) ? r_st : r_ct;
        mag_s = (oct[0] ^ oct[1]) ? r_ct : r_st;
        cneg  = oct[2] ^ oct[1];
        sneg  = oct[2];
        rnd   = r_prod + (64'd1 << (OUT_SHIFT - 1));
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_state)
            C_LOGM: begin
                op_a = {1'b0, r_m};
                op_b = {1'b0, r_m};
            end
            C_SM: begin
                op_a = {2'b00, big[35:6]};
                op_b = TWO_LN2_Q30;
            end
            C_SQM: begin
                op_a = {5'd0, trial};
                op_b = {5'd0, trial};
            end
            C_TM: begin
                op_a = {1'b0, g};
                op_b = PI_Q30;
            end
            C_T2M: begin
                op_a = {1'b0, r_t};
                op_b = {1'b0, r_t};
            end
            C_TRM: begin
                op_a = {1'b0, r_term};
                op_b = {1'b0, r_t2};
            end
            C_DVM: begin
                op_a = {1'b0, r_dvd};
                op_b = recip;
            end
            C_CHM: begin
                op_a = {1'b0, r_quo};
                op_b = {24'd0, divisor};
            end
            C_OM: begin
                op_a = {5'd0, r_r};
                op_b = {1'b0, r_oc ? mag_s : mag_c};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_m33 = r_m33;  n_m = r_m;      n_e = r_e;        n_it = r_it;
        n_frac = r_frac; n_ph = r_ph;   n_s = r_s;        n_r = r_r;
        n_bk = r_bk;    n_t = r_t;      n_t2 = r_t2;      n_term = r_term;
        n_sum = r_sum;  n_k = r_k;      n_pass = r_pass;  n_st = r_st;
        n_ct = r_ct;    n_dvd = r_dvd;  n_quo = r_quo;
        n_oc = r_oc;    n_cos = r_cos;  n_sin = r_sin;    n_done = 1'b0;
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_m33   = {i_word_a, 1'b1};
                    n_e     = 6'd32;
                    n_ph    = {i_word_b, 1'b1};
                    n_state = C_NORM;
                end
            end
            C_NORM: begin
                // One bit of normalising shift per cycle until the leading one is on top.
                if (r_m33[32]) begin
                    n_m     = r_m33[32:2];
                    n_it    = '0;
                    n_frac  = '0;
                    n_state = C_LOGM;
                end else begin
                    n_m33 = {r_m33[31:0], 1'b0};
                    n_e   = r_e - 1'b1;
                end
            end
            C_LOGM: n_state = C_LOGU;
            C_LOGU: begin
                if (sq[32:31] != 2'b00) begin
                    n_m = sq[31:1];
                    n_frac[5'd29 - r_it] = 1'b1;
                end else begin
                    n_m = sq[30:0];
                end
                if (r_it == 5'd29) begin
                    n_state = C_SM;
                end else begin
                    n_it    = r_it + 1'b1;
                    n_state = C_LOGM;
                end
            end
            C_SM: n_state = C_SU;
            C_SU: begin
                n_s     = r_prod[59:30];
                n_r     = '0;
                n_bk    = 5'd26;
                n_state = C_SQM;
            end
            C_SQM: n_state = C_SQU;
            C_SQU: begin
                if (r_prod <= nsq) begin
                    n_r = trial;
                end
                if (r_bk == '0) begin
                    n_state = C_TM;
                end else begin
                    n_bk    = r_bk - 1'b1;
                    n_state = C_SQM;
                end
            end
            C_TM: n_state = C_TU;
            C_TU: begin
                n_t     = r_prod[62:32];
                n_state = C_T2M;
            end
            C_T2M: n_state = C_T2U;
            C_T2U: begin
                n_t2    = r_prod[60:30];
                n_pass  = 1'b0;
                n_term  = r_t;
                n_sum   = $signed({2'b00, r_t});
                n_k     = 3'd1;
                n_state = C_TRM;
            end
            C_TRM: n_state = C_TRU;
            C_TRU: begin
                n_dvd   = r_prod[60:30];
                n_state = C_DVM;
            end
            C_DVM: n_state = C_DVU;
            C_DVU: begin
                n_quo   = r_prod[62:32];
                n_state = C_CHM;
            end
            C_CHM: n_state = C_CHU;
            C_CHU: begin
                // The reciprocal estimate is exact or one short; the remainder tells which.
                if (rem_est >= {23'd0, divisor}) begin
                    n_quo = r_quo + 1'b1;
                end
                n_state = C_ACC;
            end
            C_ACC: begin
                n_term = r_quo;
                n_sum  = sum_n;
                if (r_k == 3'd6) begin
                    if (!r_pass) begin
                        n_st    = clamp_unit(sum_n);
                        n_pass  = 1'b1;
                        n_term  = Q30_ONE;
                        n_sum   = $signed({2'b00, Q30_ONE});
                        n_k     = 3'd1;
                        n_state = C_TRM;
                    end else begin
                        n_ct    = clamp_unit(sum_n);
                        n_oc    = 1'b0;
                        n_state = C_OM;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = C_TRM;
                end
            end
            C_OM: n_state = C_OU;
            C_OU: begin
                if (!r_oc) begin
                    n_cos   = sat_out(rnd, cneg);
                    n_oc    = 1'b1;
                    n_state = C_OM;
                end else begin
                    n_sin   = sat_out(rnd, sneg);
                    n_done  = 1'b1;
                    n_state = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        r_m33 <= n_m33;  r_m <= n_m;      r_e <= n_e;        r_it <= n_it;
        r_frac <= n_frac; r_ph <= n_ph;   r_s <= n_s;        r_r <= n_r;
        r_bk <= n_bk;    r_t <= n_t;      r_t2 <= n_t2;      r_term <= n_term;
        r_sum <= n_sum;  r_k <= n_k;      r_pass <= n_pass;  r_st <= n_st;
        r_ct <= n_ct;    r_dvd <= n_dvd;  r_quo <= n_quo;
        r_oc <= n_oc;    r_cos <= n_cos;  r_sin <= n_sin;
    end

    assign o_done       = r_done;
    assign o_sample_cos = r_cos;
    assign o_sample_sin = r_sin;

endmodule

// File: rtl/gaussian_noise_box_muller_mt.sv
`timescale 1ns / 1ps
// Gaussian noise source: MT19937 words mapped by Box-Muller to Q4.12 sample pairs.
// Depends on gnbm_pkg, gnbm_mt and gnbm_math.
//
// Usage: each input item carries values_left, the count still needed in the
// current noise block. The block draws two MT words, a then b, and returns one
// item with a cosine and a sine sample, the sine flag and the end-of-block flag.
// Input and output both use valid/stall; an item moves on an edge with valid high
// and stall low. One item is worked on at a time and o_in_stall stays high until
// its result sits in the output register. A finished item waits there while the
// receiver stalls; the next input item is taken meanwhile and held back only at
// the point where its own result would overwrite the waiting one.
// Sequence: the two MT words are drawn, then the first word is normalised, one
// shift per leading zero, up to 32, and the arithmetic runs on the shared
// multiplier (30 log squarings, 27 square-root steps, twelve Taylor terms); the
// result is then handed over to the output register. Every 312th item adds a
// twist of the state memory.
// Reset, and any write of the seed register, starts a seeding sweep of the state
// memory, during which no item is accepted; the reset seed is 5489.
module gaussian_noise_box_muller_mt import gnbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [28:0] i_values_left,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_sample_cos,
    output logic signed [15:0] o_sample_sin,
    output logic        o_sin_valid,
    output logic        o_block_last
);

    typedef enum logic [6:0] {
        T_IDLE  = 7'b0000001,
        T_REQA  = 7'b0000010,
        T_WAITA = 7'b0000100,
        T_REQB  = 7'b0001000,
        T_WAITB = 7'b0010000,
        T_CALC  = 7'b0100000,
        T_OUT   = 7'b1000000
    } t_top_state;

    t_top_state  r_state, n_state;
    logic [31:0] r_word_a, n_word_a;
    logic        r_sinv, n_sinv;
    logic        r_last, n_last;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_cos, n_cos;
    logic [15:0] r_sin, n_sin;

    t_mt_status  mt_status;
    logic [31:0] mt_word;
    logic        mt_req;
    logic        math_start;
    logic        math_done;
    logic [15:0] math_cos, math_sin;
    logic        in_acc, out_acc, out_free;

    gnbm_mt u_mt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (mt_req),
        .o_word      (mt_word),
        .o_status    (mt_status)
    );

    gnbm_math u_math (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (math_start),
        .i_word_a     (r_word_a),
        .i_word_b     (mt_word),
        .o_done       (math_done),
        .o_sample_cos (math_cos),
        .o_sample_sin (math_sin)
    );

    assign o_in_stall = !((r_state == T_IDLE) && mt_status.ready);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign mt_req     = ((r_state == T_REQA) || (r_state == T_REQB)) && mt_status.ready;
    assign math_start = (r_state == T_WAITB) && mt_status.word_valid;

    always_comb begin
        n_state     = r_state;
        n_word_a    = r_word_a;
        n_sinv      = r_sinv;
        n_last      = r_last;
        n_cos       = r_cos;
        n_sin       = r_sin;
        n_out_valid = r_out_valid && !out_acc;
        case (r_state)
            T_IDLE: begin
                if (in_acc) begin
                    n_sinv  = (i_values_left >= 29'd2);
                    n_last  = (i_values_left <= 29'd2);
                    n_state = T_REQA;
                end
            end
            T_REQA: begin
                if (mt_status.ready) begin
                    n_state = T_WAITA;
                end
            end
            T_WAITA: begin
                if (mt_status.word_valid) begin
                    n_word_a = mt_word;
                    n_state  = T_REQB;
                end
            end
            T_REQB: begin
                if (mt_status.ready) begin
                    n_state = T_WAITB;
                end
            end
            T_WAITB: begin
                if (mt_status.word_valid) begin
                    n_state = T_CALC;
                end
            end
            T_CALC: begin
                if (math_done) begin
                    n_state = T_OUT;
                end
            end
            T_OUT: begin
                if (out_free) begin
                    n_cos       = math_cos;
                    n_sin       = r_sinv ? math_sin : 16'd0;
                    n_out_valid = 1'b1;
                    n_state     = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word_a <= n_word_a;
        r_sinv   <= n_sinv;
        r_last   <= n_last;
        r_cos    <= n_cos;
        r_sin    <= n_sin;
    end

    // The output flags follow the item held in the output register.
    logic r_out_sinv, r_out_last;
    always_ff @(posedge i_clk) begin
        if ((r_state == T_OUT) && out_free) begin
            r_out_sinv <= r_sinv;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_cos = r_cos;
    assign o_sample_sin = r_sin;
    assign o_sin_valid  = r_out_sinv;
    assign o_block_last = r_out_last;

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        math_done |-> (r_state == T_CALC))
        else $error("arithmetic finished outside the calculation state");

    a_word_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mt_status.word_valid |-> ((r_state == T_WAITA) || (r_state == T_WAITB)))
        else $error("twister word delivered while nobody waits for it");

    a_sin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sin_valid) |-> (o_sample_sin == 16'sd0))
        else $error("sine sample not cleared for an item outside the block");

    a_last_when_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sin_valid) |-> o_block_last)
        else $error("single remaining value without end of block");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the Gaussian noise source: MT19937 plus Box-Muller.
// Depends on gnbm_pkg and the top level gaussian_noise_box_muller_mt.
module tb_top;
    import gnbm_pkg::*;

    typedef struct packed {
        logic [15:0] cos_s;
        logic [15:0] sin_s;
        logic        sin_v;
        logic        last;
    } t_noise;

    typedef struct packed {
        logic [28:0] left;
        logic        sin_v;
        logic        last;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [28:0] values_left = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [15:0] sample_cos, sample_sin;
    logic        sin_valid, block_last;

    gaussian_noise_box_muller_mt u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_values_left(values_left),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_sample_cos(sample_cos), .o_sample_sin(sample_sin),
        .o_sin_valid(sin_valid), .o_block_last(block_last)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // Own copy of the generator state.
    logic [31:0] mt_state [MT_N];
    int unsigned mt_pos;
    t_noise      pending_noise [$];
    int unsigned mismatches = 0;
    int unsigned pairs_seen = 0;
    bit          calm = 1'b0;
    logic [31:0] seeds [4];

    function automatic void reseed(input logic [31:0] s);
        mt_state[0] = s;
        for (int i = 1; i < MT_N; i++)
            mt_state[i] = 32'd1812433253 * (mt_state[i-1] ^ (mt_state[i-1] >> 30)) + i;
        mt_pos = MT_N;
    endfunction

    function automatic logic [31:0] draw_word();
        logic [31:0] y, w;
        if (mt_pos >= MT_N) begin
            for (int i = 0; i < MT_N; i++) begin
                y = (mt_state[i] & 32'h80000000) | (mt_state[(i+1) % MT_N] & 32'h7fffffff);
                w = mt_state[(i + MT_M) % MT_N] ^ (y >> 1);
                if (y[0]) w = w ^ 32'h9908b0df;
                mt_state[i] = w;
            end
            mt_pos = 0;
        end
        y = mt_state[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [63:0] radius_of(input logic [31:0] a);
        logic [63:0] x, m, frac, lg, big, s, n, res, bit_v;
        int e;
        x = 2 * 64'(a) + 1;
        e = 0;
        frac = 0;
        res = 0;
        while (e < 32 && (x >> (e + 1)) != 0) e++;
        m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        for (int i = 1; i <= 30; i++) begin
            m = (m * m) >> 30;
            if (m >= 64'd2147483648) begin
                m = m >> 1;
                frac = frac | (64'd1 << (30 - i));
            end
        end
        lg = (64'(e) << 30) | frac;
        big = (64'd33 << 30) - lg;
        s = ((big >> 6) * 64'd1488522236) >> 30;
        n = s << 24;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] unit_clamp(input longint v);
        if (v < 0) return 0;
        if (v > 64'sd1073741824) return 64'd1073741824;
        return 64'(v);
    endfunction

    function automatic logic [15:0] scaled(input logic [63:0] r, input logic [63:0] mag,
                                           input bit neg);
        logic [63:0] p;
        p = (r * mag + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (neg) return (p > 32768) ? 16'h8000 : 16'(-p);
        return (p > 32767) ? 16'h7fff : p[15:0];
    endfunction

    function automatic t_noise gauss_pair(input logic [28:0] left);
        logic [31:0] a, b;
        logic [63:0] r, p, f, g, t, t2, term, st, ct, cm, sm;
        longint sum;
        logic [2:0] oct;
        bit cneg, sneg;
        t_noise o;
        a = draw_word();
        b = draw_word();
        r = radius_of(a);
        p = 2 * 64'(b) + 1;
        oct = p[32:30];
        f = p & 64'h3fffffff;
        g = oct[0] ? (64'd1073741824 - f) : f;
        t = (g * 64'd3373259426) >> 32;
        t2 = (t * t) >> 30;
        term = t;
        sum = longint'(t);
        for (int k = 1; k <= 6; k++) begin
            term = ((term * t2) >> 30) / ((2 * k) * (2 * k + 1));
            sum = (k & 1) ? sum - longint'(term) : sum + longint'(term);
        end
        st = unit_clamp(sum);
        term = 64'd1073741824;
        sum = 64'sd1073741824;
        for (int k = 1; k <= 6; k++) begin
            term = ((term * t2) >> 30) / ((2 * k - 1) * (2 * k));
            sum = (k & 1) ? sum - longint'(term) : sum + longint'(term);
        end
        ct = unit_clamp(sum);
        // Odd-numbered quarters of the octant pairs swap sine and cosine.
        cm = (oct == 1 || oct == 2 || oct == 5 || oct == 6) ? st : ct;
        sm = (oct == 1 || oct == 2 || oct == 5 || oct == 6) ? ct : st;
        cneg = oct inside {3'd2, 3'd3, 3'd4, 3'd5};
        sneg = oct[2];
        o.cos_s = scaled(r, cm, cneg);
        o.sin_v = (left >= 2);
        o.sin_s = o.sin_v ? scaled(r, sm, sneg) : 16'h0000;
        o.last = (left <= 2);
        return o;
    endfunction

    // Output side: random stall, check each accepted item against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            pairs_seen++;
            if (pending_noise.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected output item");
            end else begin
                t_noise e;
                e = pending_noise.pop_front();
                if ({sample_cos, sample_sin, sin_valid, block_last} !== e) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Sample mismatch: expected cos %0d sin %0d v %0b l %0b,",
                                 $signed(e.cos_s), $signed(e.sin_s), e.sin_v, e.last);
                        $display("                 got cos %0d sin %0d v %0b l %0b",
                                 sample_cos, sample_sin, sin_valid, block_last);
                    end
                end
            end
        end
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 10);
    end

    // Directed rows: values left with the flags read straight off the block rules;
    // the samples come from the predictor.
    t_row directed_rows [12] = '{
        '{29'd1,         1'b0, 1'b1}, '{29'd2,         1'b1, 1'b1},
        '{29'd3,         1'b1, 1'b0}, '{29'd0,         1'b0, 1'b1},
        '{29'h1fffffff,  1'b1, 1'b0}, '{29'd268435456, 1'b1, 1'b0},
        '{29'd268435457, 1'b1, 1'b0}, '{29'd1,         1'b0, 1'b1},
        '{29'd2,         1'b1, 1'b1}, '{29'd0,         1'b0, 1'b1},
        '{29'd100,       1'b1, 1'b0}, '{29'h10000000,  1'b1, 1'b0}};

    // Valid stays high after an accepted item unless idling or a quiet phase follows.
    task automatic send_item(input logic [28:0] left, input t_noise expect_item);
        while ($urandom_range(99) < 10 && !calm) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        values_left <= left;
        pending_noise = {pending_noise, expect_item};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_pair(input logic [28:0] left);
        send_item(left, gauss_pair(left));
    endtask

    task automatic write_seed(input logic [31:0] s);
        in_valid <= 1'b0;
        while (pending_noise.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        reseed(s);
    endtask

    task automatic random_phase(input int count);
        logic [28:0] left;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: left = 29'($urandom_range(2, 0));
                1: left = 29'($urandom_range(64));
                default: left = 29'($urandom);
            endcase
            send_pair(left);
        end
    endtask

    initial begin
        t_noise row_exp;
        seeds = '{32'd0, 32'hffffffff, 32'd1, $urandom};
        reseed(SEED_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[i]) begin
            row_exp = gauss_pair(directed_rows[i].left);
            row_exp.sin_v = directed_rows[i].sin_v;
            row_exp.last = directed_rows[i].last;
            send_item(directed_rows[i].left, row_exp);
        end
        random_phase(300);
        write_seed(seeds[0]);
        random_phase(100);
        write_seed(seeds[1]);
        calm = 1'b1;
        random_phase(250);
        calm = 1'b0;
        write_seed(seeds[2]);
        random_phase(150);
        write_seed(seeds[3]);
        random_phase(338);
        in_valid <= 1'b0;
        while (pending_noise.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
        $display("Checked %0d sample pairs over five seed settings, extremes included.",
                 pairs_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
